// ===== rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
package aes_pkg;

  localparam int KeyWords  = 44;
  localparam int NumRounds = 10;

  typedef enum logic [1:0] {
    REG_KEY_UPPER = 2'd0,
    REG_KEY_LOWER = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       key_load;
    logic       key_step;
    logic [3:0] key_addr;
    logic       blk_load;
    logic       blk_round;
    logic       init_add;
    logic [3:0] round;
    logic       last;
    logic       out_load;
  } cmd_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBox = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/aes_stream_if.sv =====
`timescale 1ns / 1ps
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] upper;
  logic [63:0] lower;
  modport source (output valid, output upper, output lower, input ready);
  modport sink (input valid, input upper, input lower, output ready);
endinterface

// ===== rtl/aes_datapath.sv =====
`timescale 1ns / 1ps
module aes_datapath import aes_pkg::*; (
  input  logic         clk,
  input  cmd_t         cmd,
  input  logic [127:0] key,
  input  logic [127:0] blk_in,
  output logic [127:0] blk_out
);

  // round keys, one 128-bit row per round, each row written by the expander
  logic [127:0] rk_mem [11];
  logic [127:0] rk_cur;
  logic [127:0] rk_rd;
  logic [127:0] rk_new;
  logic [127:0] state;
  logic [127:0] state_next;
  logic [127:0] ss;
  logic [127:0] mc;
  logic [31:0]  tw;

  // one key round per cycle from the working row
  always_comb begin
    tw = {SBox[rk_cur[23:16]], SBox[rk_cur[15:8]], SBox[rk_cur[7:0]], SBox[rk_cur[31:24]]}
         ^ {rcon(cmd.key_addr), 24'h0};
    rk_new[127:96] = rk_cur[127:96] ^ tw;
    rk_new[95:64]  = rk_cur[95:64] ^ rk_new[127:96];
    rk_new[63:32]  = rk_cur[63:32] ^ rk_new[95:64];
    rk_new[31:0]   = rk_cur[31:0] ^ rk_new[63:32];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      rk_cur <= key;
      rk_mem[0] <= key;
    end else if (cmd.key_step) begin
      rk_cur <= rk_new;
      rk_mem[cmd.key_addr] <= rk_new;
    end
  end

  // read address runs one ahead so the data is registered in time
  always_ff @(posedge clk) begin
    rk_rd <= rk_mem[cmd.round];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127 - 8*(4*c + r) -: 8] = SBox[state[127 - 8*(4*((c + r) % 4) + r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = ss[127 - 32*c -: 8];
      a1 = ss[119 - 32*c -: 8];
      a2 = ss[111 - 32*c -: 8];
      a3 = ss[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    if (cmd.blk_load) begin
      state_next = blk_in;
    end else if (cmd.blk_round) begin
      if (cmd.init_add) begin
        state_next = state ^ rk_rd;
      end else begin
        state_next = (cmd.last ? ss : mc) ^ rk_rd;
      end
    end else begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    state <= state_next;
    if (cmd.out_load) begin
      blk_out <= state;
    end
  end

endmodule

// ===== rtl/aes_ctrl.sv =====
`timescale 1ns / 1ps
module aes_ctrl import aes_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic key_write,
  input  logic in_fire,
  input  logic out_fire,
  output logic in_rdy,
  output logic out_vld,
  output cmd_t cmd
);

  state_t     st;
  state_t     st_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic       key_pend;
  logic       key_pend_next;
  logic       out_full;
  logic       out_full_next;
  logic       done;

  always_comb begin
    st_next = st;
    cnt_next = cnt;
    case (st)
      ST_IDLE: begin
        if (key_pend) begin
          st_next = ST_EXPAND;
          cnt_next = 4'd1;
        end else if (in_fire) begin
          st_next = ST_ROUND;
          cnt_next = 4'd0;
        end
      end
      ST_EXPAND: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'(NumRounds)) st_next = ST_IDLE;
      end
      ST_ROUND: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'(NumRounds)) st_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_full || out_fire) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  assign done = (st == ST_DONE) && (!out_full || out_fire);

  always_comb begin
    key_pend_next = key_write || (key_pend && st != ST_IDLE);
    out_full_next = done || (out_full && !out_fire);
  end

  always_comb begin
    cmd = '0;
    in_rdy = (st == ST_IDLE) && !key_pend && !key_write;
    out_vld = out_full;
    cmd.key_load = (st == ST_IDLE) && key_pend;
    cmd.key_step = (st == ST_EXPAND);
    cmd.key_addr = cnt;
    cmd.blk_load = in_fire;
    cmd.blk_round = (st == ST_ROUND);
    cmd.init_add = (cnt == 4'd0);
    cmd.round = in_fire ? 4'd0 : cnt_next;
    cmd.last = (cnt == 4'(NumRounds));
    cmd.out_load = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      cnt <= '0;
      key_pend <= 1'b0;
      out_full <= 1'b0;
    end else begin
      st <= st_next;
      cnt <= cnt_next;
      key_pend <= key_pend_next;
      out_full <= out_full_next;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> st == ST_IDLE) else $error("accept while busy");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    st == ST_ROUND |-> cnt <= 4'(NumRounds)) else $error("round count overrun");
  a_done_next: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ROUND && cnt == 4'(NumRounds)) |=> st == ST_DONE) else $error("no done");

endmodule

// ===== rtl/aes128_block_encrypt.sv =====
`timescale 1ns / 1ps
// channel  role    payload
// plain    sink    plain_upper, plain_lower
// cipher   source  cipher_upper, cipher_lower
// cfg      write   key_upper (0), key_lower (1)
// a block passes from transfer in to result through the initial key addition
// and 10 rounds in one round datapath, then a done state that loads the result
// the next block can transfer in the cycle after the result is loaded, not before
// a key write starts the key expansion once idle, one round key per cycle
// rst is synchronous; the result register holds while the sink stalls
module aes128_block_encrypt import aes_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  aes_stream_if.sink    plain,
  aes_stream_if.source  cipher,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  logic [63:0]  key_upper;
  logic [63:0]  key_lower;
  logic [127:0] blk_out;
  logic         in_fire;
  logic         out_fire;
  logic         in_rdy;
  logic         out_vld;
  logic         key_write;
  cmd_t         cmd;

  assign key_write = cfg_we && (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_UPPER: key_upper <= cfg_data;
        REG_KEY_LOWER: key_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_fire = plain.valid && in_rdy;
  assign out_fire = out_vld && cipher.ready;
  assign plain.ready = in_rdy;
  assign cipher.valid = out_vld;
  assign cipher.upper = blk_out[127:64];
  assign cipher.lower = blk_out[63:0];

  aes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .key_write(key_write), .in_fire(in_fire),
    .out_fire(out_fire), .in_rdy(in_rdy), .out_vld(out_vld), .cmd(cmd)
  );

  aes_datapath u_dp (
    .clk(clk), .cmd(cmd), .key({key_upper, key_lower}),
    .blk_in({plain.upper, plain.lower}), .blk_out(blk_out)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench import aes_pkg::*;;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } block_t;

  class cipher_scoreboard;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] round_keys [KeyWords];
    block_t expected_q [$];
    int mismatches;

    function new();
      key_hi = '0;
      key_lo = '0;
      mismatches = 0;
      foreach (round_keys[i]) round_keys[i] = '0;
    endfunction

    function logic [7:0] sb(input logic [7:0] b);
      logic [7:0] tbl [256];
      tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tbl[b];
    endfunction

    function logic [7:0] dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function void write_key(input reg_index_t idx, input logic [63:0] value);
      logic [31:0] t;
      logic [7:0] rc;
      if (idx == REG_KEY_UPPER) key_hi = value;
      else if (idx == REG_KEY_LOWER) key_lo = value;
      else return;
      round_keys[0] = key_hi[63:32];
      round_keys[1] = key_hi[31:0];
      round_keys[2] = key_lo[63:32];
      round_keys[3] = key_lo[31:0];
      rc = 8'h01;
      for (int i = 4; i < KeyWords; i++) begin
        t = round_keys[i-1];
        if (i % 4 == 0) begin
          t = {t[23:0], t[31:24]};
          t = {sb(t[31:24]) ^ rc, sb(t[23:16]), sb(t[15:8]), sb(t[7:0])};
          rc = dbl(rc);
        end
        round_keys[i] = round_keys[i-4] ^ t;
      end
    endfunction

    function block_t encrypt(input block_t pt);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      block_t ct;
      for (int i = 0; i < 8; i++) begin
        s[i] = pt.upper[63-8*i -: 8];
        s[i+8] = pt.lower[63-8*i -: 8];
      end
      for (int rnd = 0; rnd <= NumRounds; rnd++) begin
        if (rnd > 0) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[c*4+r] = sb(s[((c+r)%4)*4+r]);
          s = t;
          if (rnd != NumRounds) begin
            for (int c = 0; c < 4; c++) begin
              a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
              all = a0 ^ a1 ^ a2 ^ a3;
              s[c*4] = a0 ^ all ^ dbl(a0 ^ a1);
              s[c*4+1] = a1 ^ all ^ dbl(a1 ^ a2);
              s[c*4+2] = a2 ^ all ^ dbl(a2 ^ a3);
              s[c*4+3] = a3 ^ all ^ dbl(a3 ^ a0);
            end
          end
        end
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            s[c*4+r] ^= round_keys[rnd*4+c][31-8*r -: 8];
      end
      for (int i = 0; i < 8; i++) begin
        ct.upper[63-8*i -: 8] = s[i];
        ct.lower[63-8*i -: 8] = s[i+8];
      end
      return ct;
    endfunction

    function void note_plain(input block_t pt);
      expected_q.push_back(encrypt(pt));
    endfunction

    function void check_cipher(input block_t ct);
      block_t exp_ct;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cipher block %h", ct);
        return;
      end
      exp_ct = expected_q.pop_front();
      if (ct.upper !== exp_ct.upper || ct.lower !== exp_ct.lower) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cipher mismatch: expected %h_%h got %h_%h",
                   exp_ct.upper, exp_ct.lower, ct.upper, ct.lower);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  cipher_scoreboard sb_h;

  aes_stream_if plain_ch ();
  aes_stream_if cipher_ch ();

  initial begin
    plain_ch.valid = 1'b0;
    plain_ch.upper = '0;
    plain_ch.lower = '0;
    cipher_ch.ready = 1'b0;
  end

  aes128_block_encrypt dut (
    .clk(clk), .rst(rst), .plain(plain_ch.sink), .cipher(cipher_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receive side
  always @(posedge clk) begin
    if (!rst) begin
      if (cipher_ch.valid && cipher_ch.ready)
        sb_h.check_cipher('{cipher_ch.upper, cipher_ch.lower});
      cipher_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb_h.write_key(idx, value);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < gap_pct) begin
      plain_ch.valid <= 1'b0;
      @(posedge clk);
    end
    plain_ch.valid <= 1'b1;
    plain_ch.upper <= hi;
    plain_ch.lower <= lo;
    @(posedge clk);
    while (!plain_ch.ready) @(posedge clk);
    sb_h.note_plain('{hi, lo});
  endtask

  task automatic drain();
    plain_ch.valid <= 1'b0;
    while (sb_h.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return rnd64();
    endcase
  endfunction

  initial begin
    sb_h = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // standard test vector key
    write_reg(REG_KEY_UPPER, 64'h0001020304050607);
    write_reg(REG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();
    // extremes of the key, then one half only
    write_reg(REG_KEY_UPPER, '0);
    write_reg(REG_KEY_LOWER, '0);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    write_reg(REG_KEY_UPPER, '1);
    write_reg(REG_KEY_LOWER, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    write_reg(REG_KEY_LOWER, 64'h0123456789abcdef);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    // unknown register indexes are ignored
    cfg_we <= 1'b1; cfg_index <= 2'd2; cfg_data <= '1;
    @(posedge clk);
    cfg_index <= 2'd3;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (20) @(posedge clk);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 54; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 54; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      if ($urandom_range(1)) write_reg(REG_KEY_UPPER, pick64());
      write_reg(REG_KEY_LOWER, pick64());
      for (int k = 0; k < 75; k++) begin
        send_block(pick64(), pick64());
        if (k == 40) begin
          drain();
        end
      end
      drain();
    end
    stall_pct = 0;
    drain();
    if (sb_h.mismatches == 0 && sb_h.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== aes128_block_encrypt.f =====
rtl/aes_pkg.sv
rtl/aes_stream_if.sv
rtl/aes_datapath.sv
rtl/aes_ctrl.sv
rtl/aes128_block_encrypt.sv
tb/testbench.sv
